FILE: rtl/ntp_pkg.sv
// Shared types and constants for the number and minterm text parser.
package ntp_pkg;

  // Default queue depths
  localparam int TOK_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Truth-table masks of the three minterm literals
  localparam logic [7:0] LIT_A_MASK = 8'hF0;
  localparam logic [7:0] LIT_B_MASK = 8'hCC;
  localparam logic [7:0] LIT_C_MASK = 8'hAA;
  localparam logic [7:0] MASK_ALL   = 8'hFF;

  // Classified character, front to back
  typedef struct packed {
    logic       is_zero;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_tilde;
    logic       is_dollar;
    logic       is_percent;
    logic       is_m;
    logic       is_lit;
    logic [7:0] lit_mask;
    logic       is_digit;
    logic [3:0] digit;
  } tok_t;

  // One parse result
  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } res_t;

endpackage

FILE: rtl/ntp_fifo.sv
// Small register queue with push/full and pop/empty sides.
module ntp_fifo #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/ntp_front.sv
// Front end: classifies each input character and queues it for the parser.
module ntp_front #(
  parameter int DEPTH = ntp_pkg::TOK_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_ch,
  output logic          in_full,
  output logic          tok_valid,
  output ntp_pkg::tok_t tok,
  input  logic          tok_pop
);

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UB      = 8'h42;
  localparam logic [7:0] CH_UC      = 8'h43;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_UM      = 8'h4D;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  logic [7:0]    up;
  ntp_pkg::tok_t cls;
  logic          tok_empty;
  logic [$bits(ntp_pkg::tok_t)-1:0] tok_bits;

  // Fold lower case to upper case
  assign up = (in_ch >= CH_LA && in_ch <= CH_LZ) ? in_ch - CASE_DIFF : in_ch;

  // Character classification
  always_comb begin
    cls            = '0;
    cls.is_zero    = (in_ch == CH_NUL);
    cls.is_space   = (in_ch == CH_SPACE);
    cls.is_plus    = (in_ch == CH_PLUS);
    cls.is_minus   = (in_ch == CH_MINUS);
    cls.is_tilde   = (in_ch == CH_TILDE);
    cls.is_dollar  = (in_ch == CH_DOLLAR);
    cls.is_percent = (in_ch == CH_PERCENT);
    cls.is_m       = (up == CH_UM);
    cls.is_lit     = (up >= CH_UA && up <= CH_UC);
    if (up == CH_UA) begin
      cls.lit_mask = ntp_pkg::LIT_A_MASK;
    end else if (up == CH_UB) begin
      cls.lit_mask = ntp_pkg::LIT_B_MASK;
    end else begin
      cls.lit_mask = ntp_pkg::LIT_C_MASK;
    end
    if (up >= CH_0 && up <= CH_9) begin
      cls.is_digit = 1'b1;
      cls.digit    = 4'(up - CH_0);
    end else if (up >= CH_UA && up <= CH_UF) begin
      cls.is_digit = 1'b1;
      cls.digit    = 4'(up - CH_UA + 8'd10);
    end
  end

  ntp_fifo #(
    .DEPTH (DEPTH),
    .W     ($bits(ntp_pkg::tok_t))
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (tok_pop),
    .rdata (tok_bits),
    .empty (tok_empty)
  );

  assign tok       = ntp_pkg::tok_t'(tok_bits);
  assign tok_valid = !tok_empty;

endmodule

FILE: rtl/ntp_back.sv
// Back end: parse state machine, accumulator and minterm combiner.
module ntp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  input  logic          tok_valid,
  input  ntp_pkg::tok_t tok,
  output logic          tok_pop,
  output logic          res_push,
  output ntp_pkg::res_t res,
  input  logic          res_full
);

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_MT_SLOT  = 3'd1,
    PH_MT_TILDE = 3'd2,
    PH_NUM_M    = 3'd3,
    PH_NUM_SIGN = 3'd4,
    PH_NUM_PREF = 3'd5,
    PH_NUM_DIG  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } base_t;

  phase_t      phase_r, phase_nxt, sp;
  base_t       base_r, base_nxt;
  logic [31:0] m_off_r;
  logic [31:0] acc_r, acc_nxt, acc_upd;
  logic        use_off_r, use_off_nxt;
  logic        neg_r, neg_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        has_lit_r, has_lit_nxt;
  logic        inv_r, inv_nxt;
  logic [7:0]  fb_r, fb_nxt;
  logic        err_r, err_nxt;
  logic        take, mt, num, at_pref, dig_ok, emit;
  logic [31:0] off, num_val, emit_val;

  // Take a token; a terminator also needs room for its result
  assign take    = tok_valid && (!tok.is_zero || !res_full);
  assign tok_pop = take;

  // Final number value: sign and offset folded into one add/subtract
  assign off     = use_off_r ? m_off_r : '0;
  assign num_val = neg_r ? (off - acc_r) : (acc_r + off);

  // Digit range check and accumulation for the current radix
  always_comb begin
    case (base_r)
      BASE_HEX: begin
        dig_ok  = tok.is_digit;
        acc_upd = {acc_r[27:0], tok.digit};
      end
      BASE_BIN: begin
        dig_ok  = tok.is_digit && (tok.digit < 4'd2);
        acc_upd = {acc_r[30:0], tok.digit[0]};
      end
      default: begin
        dig_ok  = tok.is_digit && (tok.digit < 4'd10);
        acc_upd = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + 32'(tok.digit);
      end
    endcase
  end

  // Parse step
  always_comb begin
    phase_nxt   = phase_r;
    base_nxt    = base_r;
    acc_nxt     = acc_r;
    use_off_nxt = use_off_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    mask_nxt    = mask_r;
    has_lit_nxt = has_lit_r;
    inv_nxt     = inv_r;
    fb_nxt      = fb_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    emit_val    = '0;
    mt          = 1'b0;
    num         = 1'b0;
    sp          = phase_r;
    at_pref     = 1'b0;

    if (take) begin
      if (err_r) begin
        // Skip to the terminator after an error
        emit = tok.is_zero;
      end else begin
        unique case (phase_r)
          PH_START: begin
            if (!tok.is_space) begin
              if (tok.is_tilde || tok.is_lit) begin
                mt = 1'b1;
                sp = PH_MT_SLOT;
              end else if (tok.is_m) begin
                phase_nxt = PH_NUM_M;
              end else begin
                num = 1'b1;
                sp  = PH_NUM_SIGN;
              end
            end
          end
          PH_MT_SLOT, PH_MT_TILDE: begin
            mt = 1'b1;
          end
          PH_NUM_M, PH_NUM_SIGN, PH_NUM_PREF, PH_NUM_DIG: begin
            num = 1'b1;
          end
          default: begin
            err_nxt = 1'b1;
            emit    = tok.is_zero;
          end
        endcase

        // Minterm expression
        if (mt) begin
          if (tok.is_zero || tok.is_plus) begin
            if (!has_lit_r) begin
              err_nxt = 1'b1;
            end
            fb_nxt      = fb_r | mask_r;
            emit_val    = {24'd0, fb_r | mask_r};
            emit        = tok.is_zero;
            mask_nxt    = ntp_pkg::MASK_ALL;
            has_lit_nxt = 1'b0;
            inv_nxt     = 1'b0;
            phase_nxt   = PH_MT_SLOT;
          end else if (sp == PH_MT_SLOT && tok.is_tilde) begin
            inv_nxt   = 1'b1;
            phase_nxt = PH_MT_TILDE;
          end else if (tok.is_lit) begin
            mask_nxt    = mask_r & (tok.lit_mask ^ {8{inv_r}});
            has_lit_nxt = 1'b1;
            inv_nxt     = 1'b0;
            phase_nxt   = PH_MT_SLOT;
          end else begin
            err_nxt = 1'b1;
          end
        end

        // Number
        if (num) begin
          at_pref = (sp == PH_NUM_SIGN && !tok.is_minus) || (sp == PH_NUM_PREF);
          if (sp == PH_NUM_M) begin
            if (tok.is_plus) begin
              use_off_nxt = 1'b1;
              phase_nxt   = PH_NUM_SIGN;
            end else if (tok.is_zero) begin
              emit     = 1'b1;
              emit_val = m_off_r;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (sp == PH_NUM_SIGN && tok.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_NUM_PREF;
          end else if (at_pref && tok.is_dollar) begin
            base_nxt  = BASE_HEX;
            phase_nxt = PH_NUM_DIG;
          end else if (at_pref && tok.is_percent) begin
            base_nxt  = BASE_BIN;
            phase_nxt = PH_NUM_DIG;
          end else begin
            phase_nxt = PH_NUM_DIG;
            if (tok.is_zero) begin
              if (!seen_r) begin
                err_nxt = 1'b1;
              end
              emit     = 1'b1;
              emit_val = num_val;
            end else if (dig_ok) begin
              acc_nxt  = acc_upd;
              seen_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
      end
    end

    // Result goes out with the final error flag; state starts over
    res.error = err_nxt;
    res.value = err_nxt ? '0 : emit_val;
    if (emit) begin
      phase_nxt   = PH_START;
      base_nxt    = BASE_DEC;
      acc_nxt     = '0;
      use_off_nxt = 1'b0;
      neg_nxt     = 1'b0;
      seen_nxt    = 1'b0;
      mask_nxt    = ntp_pkg::MASK_ALL;
      has_lit_nxt = 1'b0;
      inv_nxt     = 1'b0;
      fb_nxt      = '0;
      err_nxt     = 1'b0;
    end
  end

  assign res_push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      base_r    <= BASE_DEC;
      m_off_r   <= '0;
      acc_r     <= '0;
      use_off_r <= 1'b0;
      neg_r     <= 1'b0;
      seen_r    <= 1'b0;
      mask_r    <= ntp_pkg::MASK_ALL;
      has_lit_r <= 1'b0;
      inv_r     <= 1'b0;
      fb_r      <= '0;
      err_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      base_r    <= base_nxt;
      acc_r     <= acc_nxt;
      use_off_r <= use_off_nxt;
      neg_r     <= neg_nxt;
      seen_r    <= seen_nxt;
      mask_r    <= mask_nxt;
      has_lit_r <= has_lit_nxt;
      inv_r     <= inv_nxt;
      fb_r      <= fb_nxt;
      err_r     <= err_nxt;
      if (cfg_we) begin
        m_off_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: rtl/number_and_minterm_text_parser.sv
// Top level of the number and minterm text parser.
//
// Input: one character per item on in_ch, written with in_push while in_full
// is low. A zero character ends the string and produces exactly one result.
// Output: out_value/out_error hold the oldest result while out_empty is low;
// out_pop takes it. out_value is zero whenever out_error is set.
// Configuration: cfg_we writes cfg_wdata into the M offset register; write
// it only while no string is in flight.
// Throughput: one character per cycle, sustained while the result queue has
// room. Each character is classified and queued; the parse state machine
// takes a terminator in the same cycle that it pushes its result.
// Stall: when the result queue is full, the parser holds a terminator until
// space frees; the character queue then fills and in_full rises. Characters
// other than the terminator keep flowing until that point.
// Reset (rst_n low, synchronous): both queues empty, parse state cleared,
// M offset zero.
module number_and_minterm_text_parser #(
  parameter int TOK_DEPTH = ntp_pkg::TOK_DEPTH,
  parameter int RES_DEPTH = ntp_pkg::RES_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_ch,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_value,
  output logic               out_error,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  logic          tok_valid;
  ntp_pkg::tok_t tok;
  logic          tok_pop;
  logic          res_push;
  logic          res_full;
  ntp_pkg::res_t res_in;
  ntp_pkg::res_t res_out;
  logic [$bits(ntp_pkg::res_t)-1:0] res_bits;

  ntp_front #(
    .DEPTH (TOK_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_ch     (in_ch),
    .in_full   (in_full),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  ntp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Result queue toward the receiver
  ntp_fifo #(
    .DEPTH (RES_DEPTH),
    .W     ($bits(ntp_pkg::res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res_out   = ntp_pkg::res_t'(res_bits);
  assign out_value = res_out.value;
  assign out_error = res_out.error;

endmodule

FILE: test/number_and_minterm_text_parser_test.sv
// Self-checking testbench for the number and minterm text parser.
`timescale 1ns / 1ps

module number_and_minterm_text_parser_test;

  typedef enum logic [2:0] {
    SCAN_LEAD, TERM_SLOT, TERM_TILDE, NUM_AFTER_M, NUM_SIGN, NUM_PREFIX, NUM_DIGITS
  } scan_phase_t;

  typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_BIN} radix_t;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_CHARS = 260;
  localparam logic [7:0] PUNCT [8] = '{"+", "~", "-", "$", "%", " ", ":", "M"};

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [7:0] in_ch = 8'd0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_value;
  logic out_error;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  // Parser state as the block should hold it
  scan_phase_t scan_phase;
  radix_t radix_sel;
  logic [31:0] acc;
  logic add_offset, negate, got_digit;
  logic [7:0] product_mask, func_byte;
  logic product_has_lit, tilde_pending, malformed;
  logic [31:0] offset_reg = 32'd0;

  ntp_pkg::res_t expected_results[$];
  ntp_pkg::res_t want;
  logic [7:0] pending_chars[$];
  logic [7:0] text_buf[$];

  int send_gap = 0, recv_gap = 0, hold_left = 0, stall_cycles = 0;
  logic idle_off = 1'b0;
  logic hold_request = 1'b0;
  int mismatch_count = 0, results_checked = 0, chars_sent = 0, chars_queued = 0;
  int strings_closed = 0, bad_strings = 0, settings_used = 0;

  number_and_minterm_text_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_ch     (in_ch),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_value (out_value),
    .out_error (out_error),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_parse();
    scan_phase = SCAN_LEAD;
    radix_sel = RADIX_DEC;
    acc = 32'd0;
    add_offset = 1'b0;
    negate = 1'b0;
    got_digit = 1'b0;
    product_mask = ntp_pkg::MASK_ALL;
    func_byte = 8'd0;
    product_has_lit = 1'b0;
    tilde_pending = 1'b0;
    malformed = 1'b0;
  endtask

  // Terminator reached: queue the result and start over
  task automatic close_string(input logic [31:0] val);
    ntp_pkg::res_t r;
    r.value = malformed ? 32'd0 : val;
    r.error = malformed;
    expected_results.push_back(r);
    strings_closed++;
    if (malformed) bad_strings++;
    clear_parse();
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the expected parse by one character
  task automatic parse_char(input logic [7:0] ch);
    logic [7:0] up, lit, dig;
    logic [31:0] val, radix;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    if (malformed) begin
      if (ch == 8'd0) close_string(32'd0);
      return;
    end
    // first non-space character picks minterm or number
    if (scan_phase == SCAN_LEAD) begin
      if (ch == " ") return;
      if (ch == "~" || (up >= "A" && up <= "C")) begin
        scan_phase = TERM_SLOT;
      end else if (up == "M") begin
        scan_phase = NUM_AFTER_M;
        return;
      end else begin
        scan_phase = NUM_SIGN;
      end
    end
    // minterm expression
    if (scan_phase == TERM_SLOT || scan_phase == TERM_TILDE) begin
      if (ch == 8'd0 || ch == "+") begin
        if (!product_has_lit) malformed = 1'b1;
        func_byte = func_byte | product_mask;
        if (ch == 8'd0) begin
          close_string({24'd0, func_byte});
        end else begin
          product_mask = ntp_pkg::MASK_ALL;
          product_has_lit = 1'b0;
          tilde_pending = 1'b0;
          scan_phase = TERM_SLOT;
        end
      end else if (scan_phase == TERM_SLOT && ch == "~") begin
        tilde_pending = 1'b1;
        scan_phase = TERM_TILDE;
      end else if (up >= "A" && up <= "C") begin
        lit = (up == "A") ? ntp_pkg::LIT_A_MASK :
              (up == "B") ? ntp_pkg::LIT_B_MASK : ntp_pkg::LIT_C_MASK;
        if (tilde_pending) lit = ~lit;
        product_mask = product_mask & lit;
        product_has_lit = 1'b1;
        tilde_pending = 1'b0;
        scan_phase = TERM_SLOT;
      end else begin
        malformed = 1'b1;
      end
      return;
    end
    // lone M or M+
    if (scan_phase == NUM_AFTER_M) begin
      if (ch == "+") begin
        add_offset = 1'b1;
        scan_phase = NUM_SIGN;
      end else if (ch == 8'd0) begin
        close_string(offset_reg);
      end else begin
        malformed = 1'b1;
      end
      return;
    end
    if (scan_phase == NUM_SIGN) begin
      scan_phase = NUM_PREFIX;
      if (ch == "-") begin
        negate = 1'b1;
        return;
      end
    end
    if (scan_phase == NUM_PREFIX) begin
      scan_phase = NUM_DIGITS;
      if (ch == "$") begin
        radix_sel = RADIX_HEX;
        return;
      end
      if (ch == "%") begin
        radix_sel = RADIX_BIN;
        return;
      end
    end
    if (ch == 8'd0) begin
      if (!got_digit) malformed = 1'b1;
      val = negate ? (32'd0 - acc) : acc;
      if (add_offset) val = val + offset_reg;
      close_string(val);
      return;
    end
    radix = (radix_sel == RADIX_HEX) ? 32'd16 : (radix_sel == RADIX_BIN) ? 32'd2 : 32'd10;
    if (up >= "0" && up <= "9") dig = up - "0";
    else if (up >= "A" && up <= "F") dig = up - "A" + 8'd10;
    else dig = 8'd255;
    if (dig >= radix) begin
      malformed = 1'b1;
      return;
    end
    acc = acc * radix + dig;
    got_digit = 1'b1;
  endtask

  // Driver: offers the oldest pending character, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        void'(pending_chars.pop_front());
        parse_char(in_ch);
        chars_sent++;
      end
      if (send_gap > 0) send_gap--;
      else if (!idle_off && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 10);
      if (pending_chars.size() != 0 && send_gap == 0) begin
        in_push <= 1'b1;
        in_ch <= pending_chars[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: takes results, checks them, stalls at random or on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d error=%0b",
                                    out_value, out_error));
        end else begin
          want = expected_results.pop_front();
          if (out_value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", out_value, want.value));
          if (out_error !== want.error)
            report_mismatch($sformatf("error %0b, expected %0b", out_error, want.error));
          results_checked++;
        end
      end
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      else if (recv_gap > 0) recv_gap--;
      else if (!idle_off && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 10);
      out_pop <= (hold_left == 0 && recv_gap == 0);
    end
  end

  // Watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("number_and_minterm_text_parser_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_offset(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    offset_reg = v;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(8'd0);
    chars_queued += s.len() + 1;
  endtask

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? (c | 8'h20) : c;
  endfunction

  // One random string: mostly well formed, some broken, some noise
  task automatic add_random_string();
    int kind, n, i, j, nlit, radix, d;
    text_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) text_buf.push_back(" ");
    end
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // number
      d = $urandom_range(0, 9);
      if (d == 0) begin
        text_buf.push_back(rand_case("M"));
      end else begin
        if (d <= 2) begin
          text_buf.push_back(rand_case("M"));
          text_buf.push_back("+");
        end
        if ($urandom_range(0, 2) == 0) text_buf.push_back("-");
        case ($urandom_range(0, 2))
          0: radix = 10;
          1: begin
            radix = 16;
            text_buf.push_back("$");
          end
          default: begin
            radix = 2;
            text_buf.push_back("%");
          end
        endcase
        n = (radix == 2) ? $urandom_range(1, 36) : $urandom_range(1, 11);
        for (i = 0; i < n; i++) begin
          d = $urandom_range(0, radix - 1);
          if (d < 10) text_buf.push_back(8'("0" + d));
          else text_buf.push_back(rand_case(8'("A" + d - 10)));
        end
      end
    end else if (kind <= 8) begin
      // minterm: products of possibly inverted literals
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        if (i > 0) text_buf.push_back("+");
        nlit = $urandom_range(1, 3);
        for (j = 0; j < nlit; j++) begin
          if ($urandom_range(0, 2) == 0) text_buf.push_back("~");
          text_buf.push_back(rand_case(8'("A" + $urandom_range(0, 2))));
        end
        if ($urandom_range(0, 9) == 0) text_buf.push_back("~");
      end
    end else begin
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) text_buf.push_back(8'($urandom_range(1, 255)));
    end
    // break some well-formed strings
    if (kind != 9 && $urandom_range(0, 5) == 0) begin
      i = $urandom_range(0, text_buf.size());
      case ($urandom_range(0, 2))
        0: if (text_buf.size() != 0)
             text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
        1: text_buf.insert(i, 8'($urandom_range(1, 255)));
        default: text_buf.insert(i, PUNCT[$urandom_range(0, 7)]);
      endcase
    end
    foreach (text_buf[k]) pending_chars.push_back(text_buf[k]);
    pending_chars.push_back(8'd0);
    chars_queued += text_buf.size() + 1;
  endtask

  initial begin
    logic [31:0] offsets [5];
    int target;
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings: field extremes and each corner of the grammar
    write_offset(32'h0000_1234);
    queue_text("");
    queue_text("   ");
    queue_text("  0");
    queue_text("-1");
    queue_text("$fFfFfFfF");
    queue_text("%101");
    queue_text("4294967297");
    queue_text("M");
    queue_text("m+-$10");
    queue_text("Mx");
    queue_text("-");
    queue_text("$");
    queue_text("%2");
    queue_text("12:");
    queue_text("~a");
    queue_text("A+b~c");
    queue_text("+A");
    queue_text("A++B");
    queue_text("A+");
    queue_text("~+A");
    queue_text("A~+B~");
    queue_text("~~A");
    queue_text("abD");
    queue_text("a b");
    wait_idle();

    // random phases, each under a different offset
    offsets = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, 32'h7FFF_FFFF};
    for (int p = 0; p < 5; p++) begin
      write_offset(offsets[p]);
      idle_off = (p == 4);
      target = chars_queued + PHASE_CHARS;
      while (chars_queued < target) add_random_string();
      // long receiver stall while the sender keeps going
      if (p == 2) hold_request = 1'b1;
      wait_idle();
    end

    $display("sent %0d characters in %0d strings (%0d malformed), %0d results checked",
             chars_sent, strings_closed, bad_strings, results_checked);
    $display("%0d offset settings, incl. extremes; one forced backpressure stall",
             settings_used);
    if (mismatch_count == 0) begin
      $display("number_and_minterm_text_parser_test: done, clean");
    end else begin
      $display("number_and_minterm_text_parser_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ntp_pkg.sv
rtl/ntp_fifo.sv
rtl/ntp_front.sv
rtl/ntp_back.sv
rtl/number_and_minterm_text_parser.sv
test/number_and_minterm_text_parser_test.sv
